FILE: sv/assert_macros.svh
// Assertion macros used by the top-level RTL file of the valve allocator.
// Depends on nothing; pulled in by the top level with an include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: sv/miova_pkg.sv
// Types and constants of the meter-in / meter-out valve allocator.
// No dependencies; imported by every module of the block.
package miova_pkg;

    localparam int CmdW    = 16;
    localparam int VelW    = 16;
    localparam int PresW   = 19;
    localparam int BandW   = 15;
    localparam int LimW    = 15;
    localparam int GainW   = 16;
    localparam int ErrW    = PresW + 1;
    localparam int FfProdW = GainW + VelW;
    localparam int ProdW   = GainW + 1 + ErrW;
    localparam int IntegW  = 40;
    localparam int RawW    = 26;
    localparam int CfgAddrW = 3;
    localparam int CfgDataW = 19;
    localparam int InDataW  = 72;
    localparam int OutDataW = 32;

    localparam logic [BandW-1:0] BandReset   = 15'd205;
    localparam logic [LimW-1:0]  LimitReset  = 15'd20480;
    localparam logic [PresW-1:0] TargetReset = 19'd30000;

    localparam logic signed [IntegW-1:0] IntegMax = {1'b0, {(IntegW-1){1'b1}}};
    localparam logic signed [IntegW-1:0] IntegMin = {1'b1, {(IntegW-1){1'b0}}};

    typedef enum logic [CfgAddrW-1:0] {
        REG_BAND   = 3'd0,
        REG_LIMIT  = 3'd1,
        REG_TARGET = 3'd2,
        REG_FF_EXT = 3'd3,
        REG_FF_RET = 3'd4,
        REG_KP     = 3'd5,
        REG_KI     = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [BandW-1:0] band;
        logic [LimW-1:0]  limit;
        logic [PresW-1:0] target;
        logic [GainW-1:0] ff_ext;
        logic [GainW-1:0] ff_ret;
        logic [GainW-1:0] kp;
        logic [GainW-1:0] ki;
    } t_cfg;

    typedef struct packed {
        logic                   extending;
        logic                   changed;
        logic [LimW-1:0]        work_cmd;
        logic [VelW-1:0]        v_dis;
        logic [GainW-1:0]       ff_gain;
        logic signed [ErrW-1:0] err;
    } t_s1;

    typedef struct packed {
        logic                    extending;
        logic                    changed;
        logic [LimW-1:0]         work_cmd;
        logic [FfProdW-1:0]      ff_prod;
        logic signed [ProdW-1:0] p_prod;
        logic signed [ProdW-1:0] i_prod;
        logic                    e_neg;
        logic                    e_pos;
    } t_s2;

    typedef struct packed {
        logic                   extending;
        logic signed [CmdW-1:0] valve_two;
        logic signed [CmdW-1:0] valve_one;
    } t_result;

endpackage

FILE: sv/miova_cfg_regs.sv
// Configuration register file of the valve allocator.
// Depends on miova_pkg.
module miova_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_we,
    input  logic [miova_pkg::CfgAddrW-1:0]  i_addr,
    input  logic [miova_pkg::CfgDataW-1:0]  i_wdata,
    output miova_pkg::t_cfg                 o_cfg
);
    import miova_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.band   <= BandReset;
            r_cfg.limit  <= LimitReset;
            r_cfg.target <= TargetReset;
            r_cfg.ff_ext <= '0;
            r_cfg.ff_ret <= '0;
            r_cfg.kp     <= '0;
            r_cfg.ki     <= '0;
        end else if (i_we) begin
            unique case (i_addr)
                REG_BAND:   r_cfg.band   <= i_wdata[BandW-1:0];
                REG_LIMIT:  r_cfg.limit  <= i_wdata[LimW-1:0];
                REG_TARGET: r_cfg.target <= i_wdata[PresW-1:0];
                REG_FF_EXT: r_cfg.ff_ext <= i_wdata[GainW-1:0];
                REG_FF_RET: r_cfg.ff_ret <= i_wdata[GainW-1:0];
                REG_KP:     r_cfg.kp     <= i_wdata[GainW-1:0];
                REG_KI:     r_cfg.ki     <= i_wdata[GainW-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: sv/miova_front.sv
// Input stage: direction mode with hysteresis, working command, discharge
// speed and pressure error. Depends on miova_pkg.
module miova_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [miova_pkg::CmdW-1:0]  i_cmd,
    input  logic signed [miova_pkg::VelW-1:0]  i_vel,
    input  logic [miova_pkg::PresW-1:0] i_cap,
    input  logic [miova_pkg::PresW-1:0] i_rod,
    input  miova_pkg::t_cfg             i_cfg,
    output logic                        o_valid,
    input  logic                        i_ready,
    output miova_pkg::t_s1              o_s1
);
    import miova_pkg::*;

    logic                  r_valid;
    logic                  r_mode;
    t_s1                   r_s1;
    logic                  n_mode;
    t_s1                   n_s1;
    logic                  load;
    logic signed [CmdW:0]  cmd_x;
    logic signed [CmdW:0]  band_x;
    logic signed [CmdW:0]  lim_x;
    logic signed [CmdW:0]  work_x;
    logic signed [VelW:0]  vdis_x;
    logic [PresW-1:0]      p_off;

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    always_comb begin
        cmd_x  = {i_cmd[CmdW-1], i_cmd};
        band_x = {2'b00, i_cfg.band};
        lim_x  = {2'b00, i_cfg.limit};
        n_mode = r_mode;
        if (cmd_x > band_x) begin
            n_mode = 1'b1;
        end else if (cmd_x < -band_x) begin
            n_mode = 1'b0;
        end
        work_x = n_mode ? cmd_x : -cmd_x;
        vdis_x = n_mode ? {i_vel[VelW-1], i_vel} : -{i_vel[VelW-1], i_vel};
        p_off  = n_mode ? i_rod : i_cap;

        n_s1.extending = n_mode;
        n_s1.changed   = n_mode != r_mode;
        if (work_x < 0) begin
            n_s1.work_cmd = '0;
        end else if (work_x > lim_x) begin
            n_s1.work_cmd = i_cfg.limit;
        end else begin
            n_s1.work_cmd = work_x[LimW-1:0];
        end
        n_s1.v_dis   = (vdis_x < 0) ? '0 : vdis_x[VelW-1:0];
        n_s1.ff_gain = n_mode ? i_cfg.ff_ext : i_cfg.ff_ret;
        n_s1.err     = signed'({1'b0, p_off}) - signed'({1'b0, i_cfg.target});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_mode  <= 1'b1;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (load) begin
                r_mode <= n_mode;
            end
        end
        if (load) begin
            r_s1 <= n_s1;
        end
    end

    assign o_valid = r_valid;
    assign o_s1    = r_s1;

endmodule

FILE: sv/miova_mult.sv
// Product stage: feedforward, proportional and integral-step products.
// Depends on miova_pkg.
module miova_mult (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  miova_pkg::t_s1  i_s1,
    input  miova_pkg::t_cfg i_cfg,
    output logic            o_valid,
    input  logic            i_ready,
    output miova_pkg::t_s2  o_s2
);
    import miova_pkg::*;

    logic r_valid;
    t_s2  r_s2;
    t_s2  n_s2;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_s2.extending = i_s1.extending;
        n_s2.changed   = i_s1.changed;
        n_s2.work_cmd  = i_s1.work_cmd;
        n_s2.ff_prod   = i_s1.ff_gain * i_s1.v_dis;
        n_s2.p_prod    = signed'({1'b0, i_cfg.kp}) * i_s1.err;
        n_s2.i_prod    = signed'({1'b0, i_cfg.ki}) * i_s1.err;
        n_s2.e_neg     = i_s1.err[ErrW-1];
        n_s2.e_pos     = !i_s1.err[ErrW-1] && (i_s1.err != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_s2 <= n_s2;
        end
    end

    assign o_valid = r_valid;
    assign o_s2    = r_s2;

endmodule

FILE: sv/miova_back.sv
// Result stage: backpressure sum with clamp, anti-windup integrator and
// valve command register. Depends on miova_pkg.
module miova_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  miova_pkg::t_s2     i_s2,
    input  miova_pkg::t_cfg    i_cfg,
    output logic               o_valid,
    input  logic               i_ready,
    output miova_pkg::t_result o_res
);
    import miova_pkg::*;

    localparam int FfShW = FfProdW - 14;
    localparam int PTermW = ProdW - 16;
    localparam int ITermW = IntegW - 16;

    logic                      r_valid;
    logic signed [IntegW-1:0]  r_integ;
    t_result                   r_res;
    logic signed [IntegW-1:0]  n_integ;
    t_result                   n_res;
    logic                      load;
    logic signed [IntegW-1:0]  integ_cur;
    logic [FfShW-1:0]          ff_sh;
    logic [LimW-1:0]           ff;
    logic [PTermW-1:0]         p_term;
    logic [ITermW-1:0]         i_term;
    logic signed [RawW-1:0]    raw;
    logic signed [RawW-1:0]    lim_x;
    logic [LimW-1:0]           bp;
    logic                      hold;
    logic signed [IntegW:0]    sum;
    logic signed [CmdW-1:0]    neg_bp;
    logic signed [CmdW-1:0]    work;

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    always_comb begin
        integ_cur = i_s2.changed ? '0 : r_integ;
        ff_sh     = i_s2.ff_prod[FfProdW-1:14];
        ff        = (ff_sh > FfShW'(i_cfg.limit)) ? i_cfg.limit : ff_sh[LimW-1:0];
        p_term    = i_s2.p_prod[ProdW-1:16];
        i_term    = integ_cur[IntegW-1:16];
        raw       = {{(RawW-LimW){1'b0}}, ff}
                  + {{(RawW-PTermW){p_term[PTermW-1]}}, p_term}
                  + {{(RawW-ITermW){i_term[ITermW-1]}}, i_term};
        lim_x     = {{(RawW-LimW){1'b0}}, i_cfg.limit};

        if (raw <= 0) begin
            bp = '0;
        end else if (raw >= lim_x) begin
            bp = i_cfg.limit;
        end else begin
            bp = raw[LimW-1:0];
        end
        hold = ((raw <= 0) && i_s2.e_neg) || ((raw >= lim_x) && i_s2.e_pos);

        sum = {integ_cur[IntegW-1], integ_cur}
            + {{(IntegW+1-ProdW){i_s2.i_prod[ProdW-1]}}, i_s2.i_prod};
        if (hold) begin
            n_integ = integ_cur;
        end else if (sum[IntegW] != sum[IntegW-1]) begin
            n_integ = sum[IntegW] ? IntegMin : IntegMax;
        end else begin
            n_integ = sum[IntegW-1:0];
        end

        neg_bp = -signed'({1'b0, bp});
        work   = signed'({1'b0, i_s2.work_cmd});
        n_res.extending = i_s2.extending;
        n_res.valve_one = i_s2.extending ? work : neg_bp;
        n_res.valve_two = i_s2.extending ? neg_bp : work;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_integ <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (load) begin
                r_integ <= n_integ;
            end
        end
        if (load) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

FILE: sv/meter_in_out_valve_allocator.sv
// Top level of the meter-in / meter-out valve allocator.
// Depends on miova_pkg, miova_cfg_regs, miova_front, miova_mult, miova_back
// and assert_macros.svh.
//
//  port group  | direction | contents
//  ------------+-----------+---------------------------------------------------
//  s_axis      | in        | tdata: command, velocity, cap_pressure, rod_pressure
//  m_axis      | out       | tdata: valve_one_cmd, valve_two_cmd; tuser: extending
//  cfg         | in        | write enable, register index, write data
//
// Three register stages: mode/error, products, integrator and result.
// Items pass the three registers in order; one item per cycle when not stalled.
// The integrator loop closes inside the result stage.
// Each stage advances when empty or drained, so bubbles close up under a stall.
// Synchronous active-low reset empties the pipe and restores register defaults.
`include "assert_macros.svh"

module meter_in_out_valve_allocator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [15:0] command, [31:16] velocity, [50:32] cap_pressure,
    // [69:51] rod_pressure, [71:70] zero
    input  logic [miova_pkg::InDataW-1:0]     i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [15:0] valve_one_cmd, [31:16] valve_two_cmd
    output logic [miova_pkg::OutDataW-1:0]    o_m_axis_tdata,
    // [0] extending
    output logic                              o_m_axis_tuser,
    input  logic                              i_cfg_we,
    input  logic [miova_pkg::CfgAddrW-1:0]    i_cfg_addr,
    input  logic [miova_pkg::CfgDataW-1:0]    i_cfg_wdata
);
    import miova_pkg::*;

    t_cfg    cfg;
    t_s1     s1;
    t_s2     s2;
    t_result res;
    logic    s1_valid;
    logic    s1_ready;
    logic    s2_valid;
    logic    s2_ready;
    logic    ext_signs_ok;
    logic    ret_signs_ok;

    miova_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_addr  (i_cfg_addr),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (cfg)
    );

    miova_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_cmd   (signed'(i_s_axis_tdata[15:0])),
        .i_vel   (signed'(i_s_axis_tdata[31:16])),
        .i_cap   (i_s_axis_tdata[50:32]),
        .i_rod   (i_s_axis_tdata[69:51]),
        .i_cfg   (cfg),
        .o_valid (s1_valid),
        .i_ready (s1_ready),
        .o_s1    (s1)
    );

    miova_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_s1    (s1),
        .i_cfg   (cfg),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_s2    (s2)
    );

    miova_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_ready (s2_ready),
        .i_s2    (s2),
        .i_cfg   (cfg),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (res)
    );

    assign o_m_axis_tdata = {res.valve_two, res.valve_one};
    assign o_m_axis_tuser = res.extending;

    assign ext_signs_ok = !res.valve_one[CmdW-1] && (res.valve_two <= 0);
    assign ret_signs_ok = !res.valve_two[CmdW-1] && (res.valve_one <= 0);

    `ASSERT_IMPL(a_extend_signs, i_clk, i_rst_n, o_m_axis_tvalid && res.extending, ext_signs_ok)
    `ASSERT_IMPL(a_retract_signs, i_clk, i_rst_n, o_m_axis_tvalid && !res.extending, ret_signs_ok)
    `ASSERT_IMPL(a_ready_when_empty, i_clk, i_rst_n, !s1_valid, o_s_axis_tready)
    `ASSERT_NEXT(a_s2_advance, i_clk, i_rst_n, s2_valid && s2_ready, o_m_axis_tvalid)

endmodule

FILE: bench/valve_command_checker.sv
`timescale 1ns / 1ps
// Checker for the meter-in / meter-out valve allocator: follows register writes,
// predicts the valve command pair of every accepted tick and compares results.
// Depends on miova_pkg.
module valve_command_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_tick_valid,
    input  logic                           i_tick_ready,
    input  logic [miova_pkg::InDataW-1:0]  i_tick_data,
    input  logic                           i_cmd_valid,
    input  logic                           i_cmd_ready,
    input  logic [miova_pkg::OutDataW-1:0] i_cmd_data,
    input  logic                           i_cmd_user,
    input  logic                           i_cfg_we,
    input  logic [miova_pkg::CfgAddrW-1:0] i_cfg_addr,
    input  logic [miova_pkg::CfgDataW-1:0] i_cfg_wdata,
    output int                             o_mismatches,
    output int                             o_pending
);
    import miova_pkg::*;

    t_cfg    knobs;
    logic    extend_mode;
    longint  integ;
    t_result cmds_due[$];
    t_result due;
    t_result seen;
    int      mismatches = 0;

    function automatic longint clamp_to(input longint x, input longint lo, input longint hi);
        if (x < lo) return lo;
        if (x > hi) return hi;
        return x;
    endfunction

    function automatic t_result allocate_valves(input logic [InDataW-1:0] tick);
        longint  cmd, vel, lim, band, p_off, gain, v_dis, ff, err, pterm, raw, bp;
        logic    next_extend;
        t_result r;
        cmd  = longint'($signed(tick[15:0]));
        vel  = longint'($signed(tick[31:16]));
        lim  = longint'(knobs.limit);
        band = longint'(knobs.band);
        next_extend = extend_mode;
        if (cmd > band) begin
            next_extend = 1'b1;
        end else if (cmd < -band) begin
            next_extend = 1'b0;
        end
        if (next_extend != extend_mode) begin
            extend_mode = next_extend;
            integ = 0;
        end
        p_off = next_extend ? longint'(tick[69:51]) : longint'(tick[50:32]);
        gain  = next_extend ? longint'(knobs.ff_ext) : longint'(knobs.ff_ret);
        v_dis = next_extend ? vel : -vel;
        if (v_dis < 0) begin
            v_dis = 0;
        end
        ff    = clamp_to((gain * v_dis) >>> 14, 0, lim);
        err   = p_off - longint'(knobs.target);
        pterm = (longint'(knobs.kp) * err) >>> 16;
        raw   = ff + pterm + (integ >>> 16);
        bp    = clamp_to(raw, 0, lim);
        // hold the integrator while the output is pinned and the error pushes further
        if (!((raw <= 0 && err < 0) || (raw >= lim && err > 0))) begin
            integ = clamp_to(integ + longint'(knobs.ki) * err,
                             longint'(IntegMin), longint'(IntegMax));
        end
        r.extending = next_extend;
        if (next_extend) begin
            r.valve_one = CmdW'(clamp_to(cmd, 0, lim));
            r.valve_two = CmdW'(-bp);
        end else begin
            r.valve_two = CmdW'(clamp_to(-cmd, 0, lim));
            r.valve_one = CmdW'(-bp);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            knobs       = '0;
            knobs.band  = BandReset;
            knobs.limit = LimitReset;
            knobs.target = TargetReset;
            extend_mode = 1'b1;
            integ       = 0;
            cmds_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_BAND:   knobs.band   = i_cfg_wdata[BandW-1:0];
                    REG_LIMIT:  knobs.limit  = i_cfg_wdata[LimW-1:0];
                    REG_TARGET: knobs.target = i_cfg_wdata[PresW-1:0];
                    REG_FF_EXT: knobs.ff_ext = i_cfg_wdata[GainW-1:0];
                    REG_FF_RET: knobs.ff_ret = i_cfg_wdata[GainW-1:0];
                    REG_KP:     knobs.kp     = i_cfg_wdata[GainW-1:0];
                    REG_KI:     knobs.ki     = i_cfg_wdata[GainW-1:0];
                    default: ;
                endcase
            end
            if (i_tick_valid && i_tick_ready) begin
                cmds_due.push_back(allocate_valves(i_tick_data));
            end
            if (i_cmd_valid && i_cmd_ready) begin
                seen = t_result'({i_cmd_user, i_cmd_data});
                if (cmds_due.size() == 0) begin
                    $display("%0t ns: result with nothing expected, got %0d %0d %0d",
                             $time, seen.valve_one, seen.valve_two, seen.extending);
                    mismatches++;
                end else begin
                    due = cmds_due.pop_front();
                    if (seen.valve_one !== due.valve_one) begin
                        $display("%0t ns: valve_one_cmd expected %0d, got %0d",
                                 $time, due.valve_one, seen.valve_one);
                        mismatches++;
                    end
                    if (seen.valve_two !== due.valve_two) begin
                        $display("%0t ns: valve_two_cmd expected %0d, got %0d",
                                 $time, due.valve_two, seen.valve_two);
                        mismatches++;
                    end
                    if (seen.extending !== due.extending) begin
                        $display("%0t ns: extending expected %0d, got %0d",
                                 $time, due.extending, seen.extending);
                        mismatches++;
                    end
                end
            end
        end
        o_pending    <= cmds_due.size();
        o_mismatches <= mismatches;
    end

endmodule

FILE: bench/tb_meter_in_out_valve_allocator.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the meter-in / meter-out valve allocator: directed and
// random control ticks over several register settings, with idling and hold-off.
// Depends on miova_pkg, meter_in_out_valve_allocator and valve_command_checker.
module tb_meter_in_out_valve_allocator;
    import miova_pkg::*;

    localparam int HalfPeriod     = 5;
    localparam int WatchdogLimit  = 1000;
    localparam int HoldOffCycles  = 60;
    localparam int NumPhases      = 7;
    localparam int RandomPerPhase = 64;
    localparam logic [CfgAddrW-1:0] RegSpare = 3'd7;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OutDataW-1:0] m_tdata;
    logic                m_tuser;
    logic                cfg_we = 1'b0;
    logic [CfgAddrW-1:0] cfg_addr = '0;
    logic [CfgDataW-1:0] cfg_wdata = '0;

    int   mismatches;
    int   pending;
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    logic hold_req = 1'b0;
    logic hold_ack = 1'b0;
    int   hold_left = 0;
    int   stall_cycles = 0;
    int   n_ticks = 0;
    int   n_settings = 0;
    int   run_left = 0;
    logic run_extend = 1'b1;
    t_cfg settings_now;

    always #HalfPeriod clk = ~clk;

    meter_in_out_valve_allocator DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    valve_command_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_tick_valid (s_tvalid),
        .i_tick_ready (s_tready),
        .i_tick_data  (s_tdata),
        .i_cmd_valid  (m_tvalid),
        .i_cmd_ready  (m_tready),
        .i_cmd_data   (m_tdata),
        .i_cmd_user   (m_tuser),
        .i_cfg_we     (cfg_we),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_wdata  (cfg_wdata),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            m_tready  <= 1'b0;
            hold_left <= HoldOffCycles;
            hold_ack  <= hold_req;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WatchdogLimit) begin
                $display("Timeout: no transfer for %0d cycles", WatchdogLimit);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic send_tick(input logic signed [CmdW-1:0] cmd,
                             input logic signed [VelW-1:0] vel,
                             input logic [PresW-1:0] cap, input logic [PresW-1:0] rod);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, rod, cap, vel, cmd};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        n_ticks++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [CfgDataW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    // junk in the unused upper bits must be dropped by the narrower registers
    task automatic apply_settings(input t_cfg c, input logic poke_spare);
        wait_drained();
        write_reg(REG_BAND,   {4'($urandom), c.band});
        write_reg(REG_LIMIT,  {4'($urandom), c.limit});
        write_reg(REG_TARGET, c.target);
        write_reg(REG_FF_EXT, {3'($urandom), c.ff_ext});
        write_reg(REG_FF_RET, {3'($urandom), c.ff_ret});
        write_reg(REG_KP,     {3'($urandom), c.kp});
        write_reg(REG_KI,     {3'($urandom), c.ki});
        if (poke_spare) begin
            write_reg(RegSpare, CfgDataW'($urandom));
        end
        cfg_we <= 1'b0;
        settings_now = c;
        n_settings++;
    endtask

    function automatic logic [PresW-1:0] pick_pressure();
        int sel, p;
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
            p = int'(settings_now.target) + int'($urandom_range(0, 6000)) - 3000;
            if (p < 0) p = 0;
            if (p > 524287) p = 524287;
            return PresW'(p);
        end
        if (sel < 9) return PresW'($urandom);
        return $urandom_range(0, 1) ? '1 : '0;
    endfunction

    // mostly runs of one direction so the backpressure integrator gets to work
    task automatic random_tick();
        int sel, mag, band;
        logic signed [CmdW-1:0] cmd;
        logic signed [VelW-1:0] vel;
        band = int'(settings_now.band);
        if (run_left == 0) begin
            run_left   = $urandom_range(3, 40);
            run_extend = 1'($urandom_range(0, 1));
        end
        run_left--;
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
            mag = $urandom_range(band + 1, 32768);
            cmd = run_extend ? CmdW'((mag > 32767) ? 32767 : mag) : CmdW'(-mag);
        end else if (sel < 8) begin
            mag = $urandom_range(0, band);
            cmd = sel[0] ? CmdW'(mag) : CmdW'(-mag);
        end else if (sel == 8) begin
            cmd = CmdW'($urandom);
        end else begin
            cmd = run_extend ? 16'sh7FFF : 16'sh8000;
        end
        if ($urandom_range(0, 1)) begin
            vel = VelW'($urandom);
        end else begin
            mag = $urandom_range(0, 6000);
            vel = run_extend ? VelW'(mag) : VelW'(-mag);
        end
        send_tick(cmd, vel, pick_pressure(), pick_pressure());
    endtask

    initial begin
        t_cfg c;
        int   ph, k;
        settings_now        = '0;
        settings_now.band   = BandReset;
        settings_now.limit  = LimitReset;
        settings_now.target = TargetReset;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: mode hysteresis at the band edges and field extremes
        send_tick(0, 0, 0, 0);
        send_tick(205, 100, 30000, 30000);
        send_tick(-205, -100, 30000, 30000);
        send_tick(-206, -32768, 524287, 0);
        send_tick(206, 32767, 0, 524287);
        send_tick(32767, 32767, 524287, 524287);
        send_tick(-32768, -32768, 0, 0);

        c = '{15'd205, 15'd20480, 19'd30000, 16'd20000, 16'd30000, 16'd4000, 16'd3000};
        apply_settings(c, 1'b0);
        send_tick(1000, 32767, 30000, 524287);
        send_tick(1000, -32768, 0, 0);
        send_tick(1000, 8000, 30000, 30000);
        repeat (3) send_tick(1000, 2000, 30000, 40000);
        send_tick(-1000, -32768, 524287, 30000);
        send_tick(-1000, 32767, 0, 30000);
        send_tick(-100, -4000, 45000, 0);
        send_tick(32767, 0, 30000, 20000);

        for (ph = 0; ph < NumPhases; ph++) begin
            case (ph)
                0: c = '{'1, '1, '1, '1, '1, '1, '1};
                1: c = '0;
                default: begin
                    c.band   = $urandom_range(0, 3) == 0 ? BandW'($urandom)
                                                         : BandW'($urandom_range(0, 2000));
                    c.limit  = LimW'($urandom);
                    c.target = $urandom_range(0, 3) == 0 ? PresW'($urandom)
                                                         : PresW'($urandom_range(10000, 60000));
                    c.ff_ext = GainW'($urandom);
                    c.ff_ret = GainW'($urandom);
                    c.kp     = GainW'($urandom) >> $urandom_range(0, 12);
                    c.ki     = GainW'($urandom) >> $urandom_range(0, 12);
                end
            endcase
            apply_settings(c, ph == 2 || ph == 5);
            if (ph < 2) begin
                tx_idle_pct = 14;
                rx_idle_pct <= 48;
            end else if (ph < 4) begin
                tx_idle_pct = 48;
                rx_idle_pct <= 14;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
            end
            if (ph % 2 == 0) begin
                hold_req <= ~hold_req;
            end
            if (ph == 1) begin
                // zero limit forces both valves shut
                send_tick(32767, 32767, 524287, 524287);
                send_tick(-32768, -32768, 524287, 524287);
            end
            for (k = 0; k < RandomPerPhase; k++) begin
                random_tick();
            end
        end

        wait_drained();
        repeat (10) @(posedge clk);
        $display("Sent %0d control ticks under %0d register settings, with sender and",
                 n_ticks, n_settings);
        $display("receiver idling, long receiver hold-offs and both direction modes");
        if (mismatches == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
